// ===== design/crng_pkg.sv =====
package crng_pkg;

  typedef enum logic [1:0] {
    FUNC_SEED     = 2'd0,
    FUNC_ENTROPY  = 2'd1,
    FUNC_GENERATE = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } core_state_e;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [NUM_WORDS-1:0][31:0] block_t;

  typedef struct packed {
    func_e       func;
    logic [63:0] seed_value;
    logic [2:0]  seed_slot;
    logic [7:0]  entropy_byte;
    logic [2:0]  byte_slot;
    logic [31:0] timestamp;
    logic [63:0] hw_random;
    logic        hw_valid;
  } cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // One column or diagonal quarter round on four words.
  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tc;
    logic [31:0] td;
    ta = a + b; td = rotl(d ^ ta, 16);
    tc = c + td; tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    qround = {ta, tb, tc, td};
  endfunction

endpackage

// ===== design/crng_in_if.sv =====
interface crng_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] seed_value;
  logic [2:0]  seed_slot;
  logic [7:0]  entropy_byte;
  logic [2:0]  byte_slot;
  logic [31:0] timestamp;
  logic [63:0] hw_random;
  logic        hw_valid;

  modport source (output valid, func, seed_value, seed_slot, entropy_byte, byte_slot,
                  timestamp, hw_random, hw_valid, input ready);
  modport sink (input valid, func, seed_value, seed_slot, entropy_byte, byte_slot,
                timestamp, hw_random, hw_valid, output ready);
endinterface

// ===== design/crng_out_if.sv =====
interface crng_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rand_word;
  logic [3:0]  word_index;
  logic        last_word;

  modport source (output valid, rand_word, word_index, last_word, input ready);
  modport sink (input valid, rand_word, word_index, last_word, output ready);
endinterface

// ===== design/crng_front.sv =====
// Accepts items into a short queue and drops the ones that have no effect.
module crng_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crng_pkg::cmd_t      in_cmd_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output crng_pkg::cmd_t      cmd_o
);

  crng_pkg::cmd_t mem_q [crng_pkg::QUEUE_DEPTH];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           keep;
  logic           push;
  logic           pop;

  assign keep = (in_cmd_i.func == crng_pkg::FUNC_ENTROPY)
             || (in_cmd_i.func == crng_pkg::FUNC_GENERATE)
             || (in_cmd_i.func == crng_pkg::FUNC_SEED && in_cmd_i.seed_slot <= 3'd4);
  assign in_ready_o  = (count_q != 2'(crng_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/crng_core.sv =====
// Holds the cipher state and runs one quarter-round column or diagonal group
// per cycle: the four quarter rounds of a group run side by side in the same cycle.
module crng_core #(
  parameter int unsigned DoubleRounds = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  crng_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    rand_word_o,
  output logic [3:0]     word_index_o,
  output logic           last_word_o
);

  localparam int unsigned RoundSteps = 2 * DoubleRounds;
  localparam int unsigned StepW = $clog2(RoundSteps);

  crng_pkg::core_state_e state_q, state_d;
  crng_pkg::block_t      cs_q;
  crng_pkg::block_t      work_q;
  logic [63:0]           count_q;
  logic [StepW-1:0]      step_q;
  logic [3:0]            idx_q;
  crng_pkg::block_t      rnd;
  crng_pkg::block_t      prep;
  logic [63:0]           cnt_inc;
  logic [2:0]            base;

  assign cnt_inc = count_q + 64'd1;

  // State after the generate preamble: counter, timestamp, hardware random.
  always_comb begin
    prep = cs_q;
    prep[12] = cnt_inc[31:0];
    prep[13] = cnt_inc[63:32];
    prep[14] = cs_q[14] ^ cmd_i.timestamp;
    if (cmd_i.hw_valid) begin
      prep[10] = cs_q[10] ^ cmd_i.hw_random[31:0];
      prep[11] = cs_q[11] ^ cmd_i.hw_random[63:32];
    end
  end

  always_comb begin
    rnd = work_q;
    if (!step_q[0]) begin
      {rnd[0], rnd[4], rnd[8],  rnd[12]} =
        crng_pkg::qround(work_q[0], work_q[4], work_q[8], work_q[12]);
      {rnd[1], rnd[5], rnd[9],  rnd[13]} =
        crng_pkg::qround(work_q[1], work_q[5], work_q[9], work_q[13]);
      {rnd[2], rnd[6], rnd[10], rnd[14]} =
        crng_pkg::qround(work_q[2], work_q[6], work_q[10], work_q[14]);
      {rnd[3], rnd[7], rnd[11], rnd[15]} =
        crng_pkg::qround(work_q[3], work_q[7], work_q[11], work_q[15]);
    end else begin
      {rnd[0], rnd[5], rnd[10], rnd[15]} =
        crng_pkg::qround(work_q[0], work_q[5], work_q[10], work_q[15]);
      {rnd[1], rnd[6], rnd[11], rnd[12]} =
        crng_pkg::qround(work_q[1], work_q[6], work_q[11], work_q[12]);
      {rnd[2], rnd[7], rnd[8],  rnd[13]} =
        crng_pkg::qround(work_q[2], work_q[7], work_q[8], work_q[13]);
      {rnd[3], rnd[4], rnd[9],  rnd[14]} =
        crng_pkg::qround(work_q[3], work_q[4], work_q[9], work_q[14]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crng_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.func == crng_pkg::FUNC_GENERATE) state_d = crng_pkg::ST_ROUND;
      end
      crng_pkg::ST_ROUND: begin
        if (step_q == StepW'(RoundSteps - 1)) state_d = crng_pkg::ST_FEED;
      end
      crng_pkg::ST_FEED: state_d = crng_pkg::ST_EMIT;
      crng_pkg::ST_EMIT: begin
        if (out_ready_i && idx_q == 4'd15) state_d = crng_pkg::ST_IDLE;
      end
      default: state_d = crng_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o  = (state_q == crng_pkg::ST_IDLE);
    out_valid_o  = (state_q == crng_pkg::ST_EMIT);
    rand_word_o  = work_q[idx_q];
    word_index_o = idx_q;
    last_word_o  = (idx_q == 4'd15);
  end

  assign base = (cmd_i.seed_slot == 3'd4) ? 3'd5 : cmd_i.seed_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crng_pkg::ST_IDLE;
      cs_q    <= {384'd0, crng_pkg::SIGMA3, crng_pkg::SIGMA2,
                  crng_pkg::SIGMA1, crng_pkg::SIGMA0};
      count_q <= '0;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        crng_pkg::ST_IDLE: begin
          step_q <= '0;
          idx_q  <= '0;
          if (cmd_valid_i) begin
            unique case (cmd_i.func)
              crng_pkg::FUNC_SEED: begin
                // Slots 0..3 reach words 4..11, slot 4 reaches words 14 and 15.
                cs_q[{base, 1'b0} + 4'd4]   <= cmd_i.seed_value[31:0];
                cs_q[{base, 1'b0} + 4'd5]   <= cmd_i.seed_value[63:32];
              end
              crng_pkg::FUNC_ENTROPY: begin
                cs_q[4'd4 + {1'b0, cmd_i.byte_slot}] <= cs_q[4'd4 + {1'b0, cmd_i.byte_slot}]
                  ^ (32'(cmd_i.entropy_byte) << {cmd_i.byte_slot[1:0], 3'b000});
              end
              crng_pkg::FUNC_GENERATE: begin
                cs_q    <= prep;
                count_q <= cnt_inc;
              end
              default: ;
            endcase
          end
        end
        crng_pkg::ST_ROUND: step_q <= step_q + StepW'(1);
        crng_pkg::ST_FEED: begin
          cs_q[4] <= cs_q[4] ^ (work_q[0] + cs_q[0]);
          cs_q[5] <= cs_q[5] ^ (work_q[1] + cs_q[1]);
        end
        crng_pkg::ST_EMIT: if (out_ready_i) idx_q <= idx_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == crng_pkg::ST_IDLE) begin
      work_q <= prep;
    end else if (state_q == crng_pkg::ST_ROUND) begin
      work_q <= rnd;
    end else if (state_q == crng_pkg::ST_FEED) begin
      for (int i = 0; i < crng_pkg::NUM_WORDS; i++) work_q[i] <= work_q[i] + cs_q[i];
    end
  end

endmodule

// ===== design/chacha20_random_generator_top.sv =====
// Channel | Direction | Payload
// in      | sink      | func, seed_value, seed_slot, entropy_byte, byte_slot, timestamp,
//         |           | hw_random, hw_valid
// out     | source    | rand_word, word_index, last_word
//
// A seed or entropy item is taken in the core's idle state; a generate item runs through
// the round state, where column and diagonal steps alternate on four quarter-round lanes,
// the feed-forward state, then the emit state with its 16 output transfers.
// A two-entry queue lets the input side run ahead while the core works.
// Reset is asynchronous and active low; the state comes up with the constants.
// Output stalls hold the current word and the core; the queue fills behind it.
module chacha20_random_generator_top #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crng_in_if.sink    in_if,
  crng_out_if.source out_if
);

  crng_pkg::cmd_t in_cmd;
  crng_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  always_comb begin
    in_cmd.func         = crng_pkg::func_e'(in_if.func);
    in_cmd.seed_value   = in_if.seed_value;
    in_cmd.seed_slot    = in_if.seed_slot;
    in_cmd.entropy_byte = in_if.entropy_byte;
    in_cmd.byte_slot    = in_if.byte_slot;
    in_cmd.timestamp    = in_if.timestamp;
    in_cmd.hw_random    = in_if.hw_random;
    in_cmd.hw_valid     = in_if.hw_valid;
  end

  crng_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_cmd_i    (in_cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  crng_core #(.DoubleRounds(DOUBLE_ROUNDS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .rand_word_o  (out_if.rand_word),
    .word_index_o (out_if.word_index),
    .last_word_o  (out_if.last_word)
  );

endmodule

// ===== design/crng_checker.sv =====
module crng_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rand_word,
  input logic [3:0]  word_index,
  input logic        last_word
);

  a_last_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 4'd15)))
    else $error("last_word does not match word_index");

  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 4'd1))
    else $error("block words not contiguous");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(rand_word) && $stable(word_index)))
    else $error("stalled output changed");

  a_gap_after_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && last_word) |=> !out_valid)
    else $error("new block started without round cycles");

endmodule

bind chacha20_random_generator_top crng_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .rand_word  (out_if.rand_word),
  .word_index (out_if.word_index),
  .last_word  (out_if.last_word)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  crng_in_if  in_if ();
  crng_out_if out_if ();

  chacha20_random_generator_top #(.DOUBLE_ROUNDS(10)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic [31:0] word;
    logic [3:0]  index;
    logic        last;
  } rand_word_t;

  logic [31:0] model_words [16];
  logic [63:0] model_count;
  rand_word_t  words_pending [$];
  int          fail_count = 0;
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void mix_quarter(ref logic [31:0] w [16], input int a, input int b,
                                      input int c, input int d);
    w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
  endfunction

  function automatic void model_reset();
    foreach (model_words[i]) model_words[i] = '0;
    model_words[0] = crng_pkg::SIGMA0; model_words[1] = crng_pkg::SIGMA1;
    model_words[2] = crng_pkg::SIGMA2; model_words[3] = crng_pkg::SIGMA3;
    model_count = '0;
  endfunction

  // Updates the key state for one command and queues the words a generate emits.
  function automatic void model_command(input crng_pkg::cmd_t c);
    logic [31:0] blk [16];
    int base;
    case (c.func)
      crng_pkg::FUNC_SEED: begin
        if (c.seed_slot <= 3'd4) begin
          base = (c.seed_slot == 3'd4) ? 14 : 4 + 2 * c.seed_slot;
          model_words[base] = c.seed_value[31:0];
          model_words[base+1] = c.seed_value[63:32];
        end
      end
      crng_pkg::FUNC_ENTROPY: begin
        model_words[4 + c.byte_slot] ^= 32'(c.entropy_byte) << (c.byte_slot[1:0] * 8);
      end
      crng_pkg::FUNC_GENERATE: begin
        model_count = model_count + 64'd1;
        model_words[12] = model_count[31:0];
        model_words[13] = model_count[63:32];
        model_words[14] ^= c.timestamp;
        if (c.hw_valid) begin
          model_words[10] ^= c.hw_random[31:0];
          model_words[11] ^= c.hw_random[63:32];
        end
        blk = model_words;
        for (int r = 0; r < 10; r++) begin
          mix_quarter(blk, 0, 4, 8, 12); mix_quarter(blk, 1, 5, 9, 13);
          mix_quarter(blk, 2, 6, 10, 14); mix_quarter(blk, 3, 7, 11, 15);
          mix_quarter(blk, 0, 5, 10, 15); mix_quarter(blk, 1, 6, 11, 12);
          mix_quarter(blk, 2, 7, 8, 13); mix_quarter(blk, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++) begin
          blk[k] = blk[k] + model_words[k];
          words_pending.push_back('{blk[k], 4'(k), k == 15});
        end
        model_words[4] ^= blk[0];
        model_words[5] ^= blk[1];
      end
      default: ;
    endcase
  endfunction

  function automatic crng_pkg::cmd_t random_cmd(input crng_pkg::func_e f);
    crng_pkg::cmd_t c;
    c.func = f;
    c.seed_value = {$urandom, $urandom};
    c.seed_slot = 3'($urandom_range(0, 4));
    c.entropy_byte = 8'($urandom);
    c.byte_slot = 3'($urandom);
    c.timestamp = $urandom;
    c.hw_random = {$urandom, $urandom};
    c.hw_valid = 1'($urandom);
    return c;
  endfunction

  task automatic send_command(input crng_pkg::cmd_t c);
    while (idle_on && $urandom_range(0, 99) < 38) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func <= c.func;
    in_if.seed_value <= c.seed_value;
    in_if.seed_slot <= c.seed_slot;
    in_if.entropy_byte <= c.entropy_byte;
    in_if.byte_slot <= c.byte_slot;
    in_if.timestamp <= c.timestamp;
    in_if.hw_random <= c.hw_random;
    in_if.hw_valid <= c.hw_valid;
    do @(posedge clk_i); while (!in_if.ready);
    model_command(c);
  endtask

  // Output side: random stalls plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk_i) begin
    rand_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (words_pending.size() == 0) begin
        $display("%0t: unexpected word %h index %0d", $time, out_if.rand_word,
                 out_if.word_index);
        fail_count++;
      end else begin
        exp_w = words_pending.pop_front();
        if (out_if.rand_word !== exp_w.word || out_if.word_index !== exp_w.index ||
            out_if.last_word !== exp_w.last) begin
          $display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
                   exp_w.word, exp_w.index, exp_w.last, out_if.rand_word,
                   out_if.word_index, out_if.last_word);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    crng_pkg::cmd_t c;
    c = random_cmd(crng_pkg::FUNC_GENERATE);
    c.timestamp = '0; c.hw_valid = 1'b0;
    send_command(c);
    for (int s = 0; s < 8; s++) begin
      c = random_cmd(crng_pkg::FUNC_SEED);
      c.seed_slot = 3'(s);
      c.seed_value = s[0] ? '1 : '0;
      send_command(c);
    end
    for (int b = 0; b < 8; b++) begin
      c = random_cmd(crng_pkg::FUNC_ENTROPY);
      c.byte_slot = 3'(b);
      c.entropy_byte = b[0] ? 8'hff : 8'h01;
      send_command(c);
    end
    c = random_cmd(crng_pkg::FUNC_NONE);
    send_command(c);
    c = random_cmd(crng_pkg::FUNC_GENERATE);
    c.timestamp = '1; c.hw_random = '1; c.hw_valid = 1'b1;
    send_command(c);
  endtask

  // Mixed traffic, including unused codes and out-of-range seed slots.
  task automatic test_random(input int n);
    crng_pkg::cmd_t c;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) idle_on = 1'b0;
      if (i == n / 2 + 40) idle_on = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) c = random_cmd(crng_pkg::FUNC_GENERATE);
      else if (pick < 65) c = random_cmd(crng_pkg::FUNC_SEED);
      else if (pick < 92) c = random_cmd(crng_pkg::FUNC_ENTROPY);
      else begin
        c = random_cmd(crng_pkg::FUNC_NONE);
        if (pick < 96) begin
          c.func = crng_pkg::FUNC_SEED; c.seed_slot = 3'($urandom_range(5, 7));
        end
      end
      send_command(c);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_command(random_cmd(crng_pkg::FUNC_GENERATE));
  endtask

  initial begin
    int waited;
    in_if.valid = 1'b0;
    in_if.func = crng_pkg::FUNC_NONE;
    in_if.seed_value = '0;
    in_if.seed_slot = '0;
    in_if.entropy_byte = '0;
    in_if.byte_slot = '0;
    in_if.timestamp = '0;
    in_if.hw_random = '0;
    in_if.hw_valid = 1'b0;
    out_if.ready = 1'b0;
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(250);
    in_if.valid <= 1'b0;
    waited = 0;
    while (words_pending.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && words_pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
